FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions on the clk_i / rst_ni domain.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge while reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks prop at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/t4fd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t4fd_pkg
// Types and constants of the 4bpp tile frame decoder.
// ----------------------------------------------------------------------------
package t4fd_pkg;

  // Result kind, carried on the output tuser.
  typedef enum logic [1:0] {
    KIND_PALETTE = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_e;

  // Mode words taken from the first two packet bytes.
  localparam logic [15:0] MODE_SMALL_A = 16'h5253;
  localparam logic [15:0] MODE_SMALL_B = 16'h5352;
  localparam logic [15:0] MODE_SMALL_C = 16'h3135;
  localparam logic [15:0] MODE_LARGE_A = 16'h4E4F;
  localparam logic [15:0] MODE_LARGE_B = 16'h3038;
  localparam logic [15:0] MODE_HDR_MIN = 16'h1000;

  // Frame geometry: 15x10 tiles (small) or 32x14 tiles (large).
  localparam logic [4:0] SMALL_LAST_COL = 5'd14;
  localparam logic [3:0] SMALL_LAST_ROW = 4'd9;
  localparam logic [4:0] LARGE_LAST_COL = 5'd31;
  localparam logic [3:0] LARGE_LAST_ROW = 4'd13;

  // Bytes a packet must hold: 32 palette bytes plus 32 bytes per tile.
  localparam logic [15:0] NEED_SMALL = 16'd4832;
  localparam logic [15:0] NEED_LARGE = 16'd14368;
  localparam logic [15:0] HDR_BYTES  = 16'd16;
  localparam logic [5:0]  HDR_POS    = 6'd16;
  localparam logic [15:0] MIN_LENGTH = 16'd2;

  localparam int unsigned OUT_TDATA_W = 56;

  typedef struct packed {
    logic        last;
    logic [3:0]  right_pixel;
    logic [3:0]  left_pixel;
    logic [6:0]  pixel_y;
    logic [7:0]  pixel_x;
    logic [23:0] rgb_colour;
    logic [3:0]  palette_index;
    kind_e       kind;
  } result_t;

endpackage

FILE: hw/rtl/tile_4bpp_frame_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_4bpp_frame_decoder_core
// Decodes a byte stream of 4bpp tile frames into palette entries and pixels.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle and answers each byte
// combinationally: a result, if the byte causes one, is captured at the
// clock edge of its transaction and is offered on the output from the next
// cycle, or once the result ahead of it has left. A two-entry output buffer
// (output register plus skid register) lets the input keep flowing while a
// result waits, so the sustained rate is one byte per cycle as long as the sink
// takes one result per cycle; tready drops only when both entries are full.
// Position is tracked by a byte counter for the header and palette, and by tile
// column, tile row and byte-in-tile counters for the pixel data, so no division
// is done.
module tile_4bpp_frame_decoder_core
  import t4fd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [7:0] data_byte, [23:8] packet_length
  input  logic        s_axis_tuser_i,   // [0] packet_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] palette_index, [27:4] rgb_colour, [35:28] pixel_x, [42:36] pixel_y,
  // [46:43] left_pixel, [50:47] right_pixel, [55:51] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o    // frame_last
);

  // Decoder state.
  logic        dropping_q, dropping_d;
  logic        header_q, header_d;
  logic        small_q, small_d;
  logic        tiles_q, tiles_d;
  logic [5:0]  pos_q, pos_d;
  logic [15:0] length_q, length_d;
  logic [7:0]  hold_q, hold_d;
  logic [4:0]  tbyte_q, tbyte_d;
  logic [4:0]  tcol_q, tcol_d;
  logic [3:0]  trow_q, trow_d;

  // Output buffer.
  logic        out_valid_q, skid_valid_q;
  result_t     out_q, skid_q;

  logic        s_fire;
  logic        out_free;
  logic        res_valid;
  result_t     res;

  logic [7:0]  data;
  logic        start;
  logic        drop;
  logic        hdr;
  logic        tiles;
  logic [5:0]  pos;
  logic [15:0] len;
  logic [15:0] mode;
  logic        mode_small, mode_large;
  logic [15:0] need;
  logic [5:0]  base;
  logic [5:0]  off;
  logic [4:0]  last_col;
  logic [3:0]  last_row;
  logic        end_col, end_row;

  assign s_axis_tready_o = !skid_valid_q;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign data  = s_axis_tdata_i[7:0];
  assign start = s_axis_tuser_i;
  assign drop  = start ? 1'b0 : dropping_q;
  assign hdr   = start ? 1'b0 : header_q;
  assign tiles = start ? 1'b0 : tiles_q;
  assign pos   = start ? 6'd0 : pos_q;
  assign len   = start ? s_axis_tdata_i[23:8] : length_q;

  assign mode       = {hold_q, data};
  assign mode_small = (mode == MODE_SMALL_A) || (mode == MODE_SMALL_B) ||
                      (mode == MODE_SMALL_C);
  assign mode_large = (mode == MODE_LARGE_A) || (mode == MODE_LARGE_B);

  assign base     = hdr ? HDR_POS : 6'd0;
  assign off      = pos - base;
  assign last_col = small_q ? SMALL_LAST_COL : LARGE_LAST_COL;
  assign last_row = small_q ? SMALL_LAST_ROW : LARGE_LAST_ROW;
  assign end_col  = (tcol_q == last_col);
  assign end_row  = (trow_q == last_row);

  always_comb begin
    dropping_d = dropping_q;
    header_d   = header_q;
    small_d    = small_q;
    tiles_d    = tiles_q;
    pos_d      = pos_q;
    length_d   = length_q;
    hold_d     = hold_q;
    tbyte_d    = tbyte_q;
    tcol_d     = tcol_q;
    trow_d     = trow_q;
    need       = NEED_LARGE;
    res        = '0;
    res_valid  = 1'b0;

    if (s_fire) begin
      dropping_d = drop;
      header_d   = hdr;
      tiles_d    = tiles;
      pos_d      = pos;
      length_d   = len;
      if (!drop) begin
        if (tiles) begin
          res_valid       = 1'b1;
          res.kind        = KIND_PIXEL;
          res.pixel_x     = {tcol_q, tbyte_q[1:0], 1'b0};
          res.pixel_y     = {trow_q, tbyte_q[4:2]};
          res.left_pixel  = data[7:4];
          res.right_pixel = data[3:0];
          tbyte_d         = tbyte_q + 5'd1;
          if (tbyte_q == 5'd31) begin
            if (end_col) begin
              tcol_d = 5'd0;
              trow_d = trow_q + 4'd1;
              if (end_row) begin
                res.last   = 1'b1;
                dropping_d = 1'b1;
              end
            end else begin
              tcol_d = tcol_q + 5'd1;
            end
          end
        end else if (pos == 6'd0) begin
          hold_d = data;
          if (len < MIN_LENGTH) begin
            res_valid  = 1'b1;
            res.kind   = KIND_REJECT;
            res.last   = 1'b1;
            dropping_d = 1'b1;
          end else begin
            pos_d = 6'd1;
          end
        end else if (pos == 6'd1) begin
          header_d = (mode > MODE_HDR_MIN);
          if (mode_small) begin
            small_d = 1'b1;
          end else if (mode_large) begin
            small_d = 1'b0;
          end
          need  = (small_d ? NEED_SMALL : NEED_LARGE) + (header_d ? HDR_BYTES : 16'd0);
          pos_d = 6'd2;
          if (len < need) begin
            res_valid  = 1'b1;
            res.kind   = KIND_REJECT;
            res.last   = 1'b1;
            dropping_d = 1'b1;
          end else if (!header_d) begin
            res_valid         = 1'b1;
            res.kind          = KIND_PALETTE;
            res.palette_index = 4'd0;
            res.rgb_colour    = {data[3:0], 4'h0, data[7:4], 4'h0, hold_q[3:0], 4'h0};
          end
        end else begin
          pos_d = pos + 6'd1;
          // Header bytes fall through here and only advance the byte counter.
          if (pos >= base) begin
            if (!off[0]) begin
              hold_d = data;
            end else begin
              res_valid         = 1'b1;
              res.kind          = KIND_PALETTE;
              res.palette_index = off[4:1];
              res.rgb_colour    = {data[3:0], 4'h0, data[7:4], 4'h0, hold_q[3:0], 4'h0};
            end
            if (off[4:0] == 5'd31) begin
              tiles_d = 1'b1;
              tbyte_d = 5'd0;
              tcol_d  = 5'd0;
              trow_d  = 4'd0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dropping_q <= 1'b1;
      header_q   <= 1'b0;
      small_q    <= 1'b0;
      tiles_q    <= 1'b0;
      pos_q      <= 6'd0;
      length_q   <= 16'd0;
      hold_q     <= 8'd0;
      tbyte_q    <= 5'd0;
      tcol_q     <= 5'd0;
      trow_q     <= 4'd0;
    end else begin
      dropping_q <= dropping_d;
      header_q   <= header_d;
      small_q    <= small_d;
      tiles_q    <= tiles_d;
      pos_q      <= pos_d;
      length_q   <= length_d;
      hold_q     <= hold_d;
      tbyte_q    <= tbyte_d;
      tcol_q     <= tcol_d;
      trow_q     <= trow_d;
    end
  end

  // A new result can only arrive while the skid register is empty.
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {5'd0, out_q.right_pixel, out_q.left_pixel, out_q.pixel_y,
                            out_q.pixel_x, out_q.rgb_colour, out_q.palette_index};

endmodule

FILE: hw/rtl/t4fd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t4fd_checker
// Port-level assertions for the 4bpp tile frame decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module t4fd_checker
  import t4fd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready_i,
  input logic                   m_axis_tvalid_i,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  input logic [1:0]             m_axis_tuser_i,
  input logic                   m_axis_tlast_i
);

  `ASSERT_CLK(a_out_hold, m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i), "stalled output transaction changed")
  `ASSERT_CLK(a_stall_needs_output, !s_axis_tready_i |-> m_axis_tvalid_i, "input stalled with an empty output")
  `ASSERT_CLK(a_reject_shape, m_axis_tvalid_i && m_axis_tuser_i == KIND_REJECT |-> m_axis_tlast_i && m_axis_tdata_i == '0, "rejection must be last with zero data")
  `ASSERT_CLK(a_palette_not_last, m_axis_tvalid_i && m_axis_tuser_i == KIND_PALETTE |-> !m_axis_tlast_i, "palette entry marked last")
  `ASSERT_CLK(a_pixel_row_range, m_axis_tvalid_i && m_axis_tuser_i == KIND_PIXEL |-> m_axis_tdata_i[42:36] <= 7'd111, "pixel row out of frame")

endmodule

bind tile_4bpp_frame_decoder_core t4fd_checker u_t4fd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
